>>> hw/rtl/asp_pkg.sv
// Package: request codes, status codes and constants of the attribute store.
`timescale 1ns / 1ps
package asp_pkg;

  typedef enum logic [2:0] {
    ACT_WRITE   = 3'd0,
    ACT_PREPARE = 3'd1,
    ACT_EXECUTE = 3'd2,
    ACT_CANCEL  = 3'd3,
    ACT_READ    = 3'd4,
    ACT_READLEN = 3'd5,
    ACT_CLEAR   = 3'd6,
    ACT_NONE    = 3'd7
  } action_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_QUEUE_FULL = 2'd1,
    ST_BAD_OFFSET = 2'd2,
    ST_RSVD       = 2'd3
  } status_e;

  localparam logic [15:0] CCC_HANDLE_A = 16'h0012;
  localparam logic [15:0] CCC_HANDLE_B = 16'h0017;
  localparam logic [15:0] CCC_HANDLE_C = 16'h0036;
  localparam logic [15:0] CCC_HANDLE_D = 16'h003b;

  localparam int unsigned MAX_RESULTS = 32;
  localparam int unsigned ALPHA_LEN   = 27;

  function automatic logic [7:0] alpha_byte(input logic [7:0] idx);
    logic [7:0] b;
    b = (idx < 8'd26) ? (8'h61 + idx) : 8'h00;
    return b;
  endfunction

endpackage

>>> hw/rtl/asp_search.sv
// First-match search of a key over a row of stored handles.
`timescale 1ns / 1ps
module asp_search #(
  parameter int unsigned N  = 10,
  parameter int unsigned IW = 4
) (
  input  logic [N-1:0][15:0] handles_i,
  input  logic [15:0]        key_i,
  output logic               hit_o,
  output logic [IW-1:0]      idx_o
);
  always_comb begin
    hit_o = 1'b0;
    idx_o = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (handles_i[i] == key_i) begin
        hit_o = 1'b1;
        idx_o = IW'(i);
      end
    end
  end
endmodule

>>> hw/rtl/attribute_store_prepared_writes_core.sv
// Top level: handle-keyed attribute store with prepared-write queues.
`timescale 1ns / 1ps
// One request is taken at a time; in_ready_o is high only while the block is
// idle. Write, prepare, cancel, clear, read-length and unused requests pass
// through idle, work and respond, and give a single result. A read requests
// each streamed byte from the value memory and then outputs it; a read that
// copies nothing goes through respond instead. Execute scans each queue in turn;
// for each busy, nonempty queue that finds an entry it copies one byte per cycle
// from the queue memory into the value memory, then drains. Output stalls hold
// the respond and read-output states. No clearing pass after reset.
module attribute_store_prepared_writes_core #(
  parameter int unsigned NUM_ENTRIES = 10,
  parameter int unsigned NUM_QUEUES  = 2,
  parameter int unsigned VALUE_BYTES = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  asp_pkg::action_e     action_i,
  input  logic [15:0]          handle_i,
  input  logic [15:0]          offset_i,
  input  logic [15:0]          length_i,
  input  logic [4:0]           position_i,
  input  logic [7:0]           data_byte_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output asp_pkg::status_e     status_o,
  output logic [7:0]           read_byte_o,
  output logic                 has_byte_o,
  output logic [15:0]          byte_count_o,
  output logic                 last_o
);
  import asp_pkg::*;

  localparam int unsigned EIW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam int unsigned QIW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int unsigned LW  = $clog2(VALUE_BYTES + 1);
  localparam int unsigned EDEPTH = NUM_ENTRIES * VALUE_BYTES;
  localparam int unsigned QDEPTH = NUM_QUEUES * VALUE_BYTES;
  localparam int unsigned EAW = (EDEPTH > 1) ? $clog2(EDEPTH) : 1;
  localparam int unsigned QAW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_WORK     = 8'b0000_0010,
    S_EX_SCAN  = 8'b0000_0100,
    S_EX_COPY  = 8'b0000_1000,
    S_EX_DRAIN = 8'b0001_0000,
    S_RD_REQ   = 8'b0010_0000,
    S_RD_OUT   = 8'b0100_0000,
    S_RESP     = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  action_e     act_q;
  logic [15:0] hdl_q, off_q, len_q;
  logic [4:0]  pos_q;
  logic [7:0]  dat_q;

  logic [NUM_ENTRIES-1:0][15:0]  ent_hdl_q;
  logic [NUM_ENTRIES-1:0][LW-1:0] ent_len_q;
  logic [NUM_QUEUES-1:0][15:0]   q_hdl_q;
  logic [NUM_QUEUES-1:0][LW-1:0] q_len_q;
  logic [QDEPTH-1:0]             q_vld_q;
  logic [7:0]  cc_val_q;
  logic [15:0] cc_hdl_q;

  logic [7:0] emem [EDEPTH];
  logic [7:0] qmem [QDEPTH];
  logic [7:0] erdata_q, qrdata_q;

  logic [QIW-1:0] qj_q;
  logic [EIW-1:0] ex_ent_q;
  logic [LW-1:0]  cp_k_q, cp_kw_q;
  logic           cp_v_q, cp_vld_q;

  logic           rd_alpha_q;
  logic [EIW-1:0] rd_ent_q;
  logic [5:0]     rd_j_q, rd_n_q;

  status_e     resp_st_q;
  logic [15:0] resp_cnt_q;

  logic        out_valid_q;
  status_e     out_st_q;
  logic [7:0]  out_byte_q;
  logic        out_has_q, out_last_q;
  logic [15:0] out_cnt_q;

  // search
  logic [15:0]    key;
  logic           hit, zhit;
  logic [EIW-1:0] hidx, zidx;

  assign key = (state_q == S_EX_SCAN) ? q_hdl_q[qj_q] : hdl_q;

  asp_search #(.N(NUM_ENTRIES), .IW(EIW)) u_find (
    .handles_i(ent_hdl_q), .key_i(key), .hit_o(hit), .idx_o(hidx)
  );
  asp_search #(.N(NUM_ENTRIES), .IW(EIW)) u_free (
    .handles_i(ent_hdl_q), .key_i(16'h0000), .hit_o(zhit), .idx_o(zidx)
  );

  logic           ent_ok;
  logic [EIW-1:0] ent_idx;
  assign ent_ok  = hit | zhit;
  assign ent_idx = hit ? hidx : zidx;

  // queue search
  logic           qhit, qfree;
  logic [QIW-1:0] qmidx, qfidx, qidx;
  always_comb begin
    qhit = 1'b0; qfree = 1'b0; qmidx = '0; qfidx = '0;
    for (int i = NUM_QUEUES - 1; i >= 0; i--) begin
      if (q_hdl_q[i] == hdl_q) begin qhit = 1'b1; qmidx = QIW'(i); end
      if (q_hdl_q[i] == 16'h0000) begin qfree = 1'b1; qfidx = QIW'(i); end
    end
  end
  assign qidx = qhit ? qmidx : qfidx;

  logic is_cc, slot_free, q_last;
  assign is_cc = ((act_q == ACT_WRITE) || (act_q == ACT_PREPARE)) &&
                 ((hdl_q == CCC_HANDLE_A) || (hdl_q == CCC_HANDLE_B) ||
                  (hdl_q == CCC_HANDLE_C) || (hdl_q == CCC_HANDLE_D));
  assign slot_free = !out_valid_q || out_ready_i;
  assign q_last = (qj_q == QIW'(NUM_QUEUES - 1));

  // write length and prepare size
  logic [LW-1:0] wlen;
  logic [16:0]   psum, psize;
  assign wlen  = (len_q > 16'(VALUE_BYTES)) ? LW'(VALUE_BYTES) : LW'(len_q);
  assign psum  = {1'b0, len_q} + {1'b0, off_q};
  assign psize = (psum > 17'(VALUE_BYTES)) ? (17'(VALUE_BYTES) - {1'b0, off_q})
                                            : {1'b0, len_q};

  // read length
  logic [15:0] vlen, avail, rn;
  assign vlen  = hit ? 16'(ent_len_q[hidx]) : 16'(ALPHA_LEN);
  assign avail = (off_q > vlen) ? 16'h0000 : (vlen - off_q);
  always_comb begin
    rn = avail;
    if (rn > len_q) rn = len_q;
    if (rn > 16'(MAX_RESULTS)) rn = 16'(MAX_RESULTS);
  end

  logic [7:0] rd_pos;
  assign rd_pos = 8'(off_q) + 8'(rd_j_q);

  // memory ports
  logic           e_we;
  logic [EAW-1:0] e_wa, e_ra;
  logic [7:0]     e_wd;
  logic           q_we;
  logic [QAW-1:0] q_wa, q_ra;

  assign q_ra = QAW'(qj_q * VALUE_BYTES) + QAW'(cp_k_q);
  assign q_wa = QAW'(qidx * VALUE_BYTES) + QAW'(off_q) + QAW'(pos_q);
  assign q_we = (state_q == S_WORK) && (act_q == ACT_PREPARE) && !is_cc &&
                (qhit || qfree) && (off_q <= 16'(VALUE_BYTES)) &&
                ({12'h000, pos_q} < psize);
  assign e_ra = EAW'(rd_ent_q * VALUE_BYTES) + EAW'(rd_pos);

  always_comb begin
    e_we = 1'b0;
    e_wa = EAW'(ex_ent_q * VALUE_BYTES) + EAW'(cp_kw_q);
    e_wd = cp_vld_q ? qrdata_q : 8'h00;
    if (cp_v_q) begin
      e_we = 1'b1;
    end else if ((state_q == S_WORK) && (act_q == ACT_WRITE) && !is_cc && ent_ok &&
                 ({3'b000, pos_q} < 8'(wlen))) begin
      e_we = 1'b1;
      e_wa = EAW'(ent_idx * VALUE_BYTES) + EAW'(pos_q);
      e_wd = dat_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (e_we) emem[e_wa] <= e_wd;
    if (state_q == S_RD_REQ) erdata_q <= emem[e_ra];
    if (q_we) qmem[q_wa] <= dat_q;
    if (state_q == S_EX_COPY) qrdata_q <= qmem[q_ra];
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:     if (in_valid_i) state_d = S_WORK;
      S_WORK: begin
        if (is_cc) state_d = S_RESP;
        else if (act_q == ACT_EXECUTE) state_d = S_EX_SCAN;
        else if ((act_q == ACT_READ) && (rn != 16'h0000)) state_d = S_RD_REQ;
        else state_d = S_RESP;
      end
      S_EX_SCAN: begin
        if ((q_hdl_q[qj_q] != 16'h0000) && ent_ok && (q_len_q[qj_q] != '0)) begin
          state_d = S_EX_COPY;
        end else if (q_last) begin
          state_d = S_RESP;
        end
      end
      S_EX_COPY:  if (cp_k_q == q_len_q[qj_q] - LW'(1)) state_d = S_EX_DRAIN;
      S_EX_DRAIN: state_d = q_last ? S_RESP : S_EX_SCAN;
      S_RD_REQ:   state_d = S_RD_OUT;
      S_RD_OUT: begin
        if (slot_free) state_d = (rd_j_q == rd_n_q - 6'd1) ? S_IDLE : S_RD_REQ;
      end
      S_RESP:     if (slot_free) state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      ent_hdl_q <= '0;
      ent_len_q <= '0;
      q_hdl_q   <= '0;
      q_len_q   <= '0;
      q_vld_q   <= '0;
      cc_val_q  <= '0;
      cc_hdl_q  <= '0;
      cp_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cp_v_q  <= (state_q == S_EX_COPY);
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;

      if (state_q == S_WORK) begin
        if (is_cc) begin
          if (pos_q == 5'd0) begin
            cc_val_q <= dat_q;
            cc_hdl_q <= hdl_q;
          end
        end else begin
          case (act_q)
            ACT_WRITE: begin
              if (ent_ok) begin
                ent_hdl_q[ent_idx] <= hdl_q;
                ent_len_q[ent_idx] <= wlen;
              end
            end
            ACT_PREPARE: begin
              if (qhit || qfree) begin
                if (!qhit) begin
                  q_hdl_q[qidx] <= hdl_q;
                  q_len_q[qidx] <= '0;
                  for (int b = 0; b < VALUE_BYTES; b++) begin
                    q_vld_q[qidx * VALUE_BYTES + b] <= 1'b0;
                  end
                end
                if (off_q <= 16'(VALUE_BYTES)) begin
                  q_len_q[qidx] <= LW'(psize) + LW'(off_q);
                  if (q_we) q_vld_q[q_wa] <= 1'b1;
                end
              end
            end
            ACT_CANCEL: q_hdl_q <= '0;
            ACT_CLEAR: begin
              ent_hdl_q <= '0;
              ent_len_q <= '0;
              q_hdl_q   <= '0;
              q_len_q   <= '0;
            end
            default: ;
          endcase
        end
      end

      if ((state_q == S_EX_SCAN) && (q_hdl_q[qj_q] != 16'h0000) && ent_ok) begin
        ent_hdl_q[ent_idx] <= q_hdl_q[qj_q];
        ent_len_q[ent_idx] <= q_len_q[qj_q];
      end
      if (((state_q == S_EX_SCAN) && (state_d == S_RESP)) ||
          ((state_q == S_EX_DRAIN) && q_last)) begin
        q_hdl_q <= '0;
      end

      if ((state_q == S_RESP) && slot_free) begin
        out_valid_q <= 1'b1;
      end
      if ((state_q == S_RD_OUT) && slot_free) begin
        out_valid_q <= 1'b1;
      end
    end
  end

  // payload and counters
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      act_q <= action_i;
      hdl_q <= handle_i;
      off_q <= offset_i;
      len_q <= length_i;
      pos_q <= position_i;
      dat_q <= data_byte_i;
    end
    cp_kw_q  <= cp_k_q;
    cp_vld_q <= q_vld_q[q_ra];
    case (state_q)
      S_WORK: begin
        qj_q       <= '0;
        rd_j_q     <= '0;
        rd_n_q     <= 6'(rn);
        rd_alpha_q <= !hit;
        rd_ent_q   <= hidx;
        resp_cnt_q <= (act_q == ACT_READLEN && !is_cc) ? avail : 16'h0000;
        resp_st_q  <= ST_OK;
        if ((act_q == ACT_PREPARE) && !is_cc) begin
          if (!(qhit || qfree)) resp_st_q <= ST_QUEUE_FULL;
          else if (off_q > 16'(VALUE_BYTES)) resp_st_q <= ST_BAD_OFFSET;
        end
      end
      S_EX_SCAN: begin
        ex_ent_q <= ent_idx;
        cp_k_q   <= '0;
        if (state_d == S_EX_SCAN) qj_q <= qj_q + QIW'(1);
      end
      S_EX_COPY:  cp_k_q <= cp_k_q + LW'(1);
      S_EX_DRAIN: if (!q_last) qj_q <= qj_q + QIW'(1);
      S_RD_OUT: begin
        if (slot_free) begin
          out_st_q   <= ST_OK;
          out_byte_q <= rd_alpha_q ? alpha_byte(rd_pos) : erdata_q;
          out_has_q  <= 1'b1;
          out_cnt_q  <= 16'(rd_n_q);
          out_last_q <= (rd_j_q == rd_n_q - 6'd1);
          rd_j_q     <= rd_j_q + 6'd1;
        end
      end
      S_RESP: begin
        if (slot_free) begin
          out_st_q   <= resp_st_q;
          out_byte_q <= 8'h00;
          out_has_q  <= 1'b0;
          out_cnt_q  <= resp_cnt_q;
          out_last_q <= 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = out_st_q;
  assign read_byte_o  = out_byte_q;
  assign has_byte_o   = out_has_q;
  assign byte_count_o = out_cnt_q;
  assign last_o       = out_last_q;

  logic cc_seen;
  assign cc_seen = (cc_hdl_q != 16'h0000) || (cc_val_q != 8'h00);

  a_take_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("transfer taken while busy");
  a_byte_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && has_byte_o |-> status_o == ST_OK && byte_count_o != 16'h0000 &&
    byte_count_o <= 16'(MAX_RESULTS))
    else $error("read byte with bad status or count");
  a_copy_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cp_v_q |-> $past(state_q == S_EX_COPY))
    else $error("copy write without queue read");
  a_cc_hdl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cc_seen |-> cc_hdl_q == CCC_HANDLE_A || cc_hdl_q == CCC_HANDLE_B ||
    cc_hdl_q == CCC_HANDLE_C || cc_hdl_q == CCC_HANDLE_D || cc_hdl_q == 16'h0000)
    else $error("client config handle out of set");

endmodule
